// ===== sv/matp_pkg.sv =====
// Shared types and constants for the MAC address text parser.
// No dependencies; imported by every module of the block.
package matp_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned MAC_W  = 48;
    localparam int unsigned NIB_W  = 4;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
    localparam logic [NIB_W-1:0]  NIB_TEN   = 4'd10;

    // character positions (0 based)
    localparam logic [POS_W-1:0] POS_MAX       = 5'd31;
    localparam logic [POS_W-1:0] POS_LONG_SEP0 = 5'd2;
    localparam logic [POS_W-1:0] POS_LONG_SEP1 = 5'd5;
    localparam logic [POS_W-1:0] POS_LONG_SEP2 = 5'd8;
    localparam logic [POS_W-1:0] POS_LONG_SEP3 = 5'd11;
    localparam logic [POS_W-1:0] POS_LONG_SEP4 = 5'd14;
    localparam logic [POS_W-1:0] POS_MID_SEP0  = 5'd4;
    localparam logic [POS_W-1:0] POS_MID_SEP1  = 5'd9;
    localparam logic [POS_W-1:0] LEN_LONG      = 5'd17;
    localparam logic [POS_W-1:0] LEN_MIDDLE    = 5'd14;
    localparam logic [POS_W-1:0] LEN_SHORT     = 5'd12;
    localparam logic [POS_W-1:0] LAST_LONG     = 5'd16;
    localparam logic [POS_W-1:0] LAST_MIDDLE   = 5'd13;
    localparam logic [POS_W-1:0] LAST_SHORT    = 5'd11;

    typedef enum logic [1:0] {
        FMT_LONG   = 2'd0,
        FMT_MIDDLE = 2'd1,
        FMT_SHORT  = 2'd2
    } t_fmt;

    typedef struct packed {
        logic             is_hex;
        logic [NIB_W-1:0] nibble;
        logic             is_sep;
    } t_char_class;

    typedef struct packed {
        logic             valid;
        t_fmt             fmt;
        logic [MAC_W-1:0] mac;
    } t_result;

endpackage

// ===== sv/matp_char_decode.sv =====
// Character classifier: hex digit value and separator detect.
// Depends on matp_pkg.
module matp_char_decode (
    input  logic [matp_pkg::CHAR_W-1:0] i_char,
    output matp_pkg::t_char_class       o_class
);
    import matp_pkg::*;

    logic is_dec;
    logic is_lo;
    logic is_up;

    assign is_dec = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_lo  = (i_char >= CH_LO_A) && (i_char <= CH_LO_F);
    assign is_up  = (i_char >= CH_UP_A) && (i_char <= CH_UP_F);

    always_comb begin
        o_class.is_hex = is_dec || is_lo || is_up;
        o_class.is_sep = (i_char == CH_COLON) || (i_char == CH_DASH);
        if (is_dec) begin
            o_class.nibble = NIB_W'(i_char - CH_ZERO);
        end else if (is_lo) begin
            o_class.nibble = NIB_W'(i_char - CH_LO_A) + NIB_TEN;
        end else if (is_up) begin
            o_class.nibble = NIB_W'(i_char - CH_UP_A) + NIB_TEN;
        end else begin
            o_class.nibble = '0;
        end
    end

endmodule

// ===== sv/matp_form_track.sv =====
// Per-string state: position, nibble accumulator and form checks.
// Depends on matp_pkg; fed by matp_char_decode.
module matp_form_track (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_beat,
    input  logic                        i_last,
    input  logic [matp_pkg::CHAR_W-1:0] i_char,
    input  matp_pkg::t_char_class       i_class,
    output matp_pkg::t_result           o_result
);
    import matp_pkg::*;

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [MAC_W-1:0]  r_acc,  n_acc;
    logic              r_lok,  n_lok;
    logic              r_mok,  n_mok;
    logic              r_sok,  n_sok;
    logic [CHAR_W-1:0] r_lsep, n_lsep;
    logic [CHAR_W-1:0] r_msep, n_msep;

    always_comb begin
        n_pos  = (r_pos < POS_MAX) ? r_pos + 1'b1 : r_pos;
        n_acc  = i_class.is_hex ? {r_acc[MAC_W-NIB_W-1:0], i_class.nibble} : r_acc;
        n_lok  = r_lok;
        n_mok  = r_mok;
        n_sok  = r_sok;
        n_lsep = r_lsep;
        n_msep = r_msep;

        // long form
        if (r_pos == POS_LONG_SEP0) begin
            if (i_class.is_sep) n_lsep = i_char;
            else                n_lok  = 1'b0;
        end else if (r_pos == POS_LONG_SEP1 || r_pos == POS_LONG_SEP2 ||
                     r_pos == POS_LONG_SEP3 || r_pos == POS_LONG_SEP4) begin
            if (i_char != r_lsep) n_lok = 1'b0;
        end else if (r_pos < LEN_LONG) begin
            if (!i_class.is_hex) n_lok = 1'b0;
        end

        // middle form
        if (r_pos == POS_MID_SEP0) begin
            if (i_class.is_sep) n_msep = i_char;
            else                n_mok  = 1'b0;
        end else if (r_pos == POS_MID_SEP1) begin
            if (i_char != r_msep) n_mok = 1'b0;
        end else if (r_pos < LEN_MIDDLE) begin
            if (!i_class.is_hex) n_mok = 1'b0;
        end

        // short form
        if (r_pos < LEN_SHORT && !i_class.is_hex) n_sok = 1'b0;
    end

    // result for a final character at the current position
    always_comb begin
        o_result.valid = 1'b0;
        o_result.fmt   = FMT_LONG;
        if (r_pos != POS_MAX) begin
            if (r_pos == LAST_LONG && n_lok) begin
                o_result.valid = 1'b1;
                o_result.fmt   = FMT_LONG;
            end else if (r_pos == LAST_MIDDLE && n_mok) begin
                o_result.valid = 1'b1;
                o_result.fmt   = FMT_MIDDLE;
            end else if (r_pos == LAST_SHORT && n_sok) begin
                o_result.valid = 1'b1;
                o_result.fmt   = FMT_SHORT;
            end
        end
        o_result.mac = o_result.valid ? n_acc : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last)) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_lok  <= 1'b1;
            r_mok  <= 1'b1;
            r_sok  <= 1'b1;
            r_lsep <= '0;
            r_msep <= '0;
        end else if (i_beat) begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_lok  <= n_lok;
            r_mok  <= n_mok;
            r_sok  <= n_sok;
            r_lsep <= n_lsep;
            r_msep <= n_msep;
        end
    end

endmodule

// ===== sv/mac_address_text_parser_top.sv =====
// Top level of the MAC address text parser.
// Depends on matp_pkg, matp_char_decode and matp_form_track.
//
// Usage:
//   Slave stream carries one ASCII character per beat in tdata; tlast marks
//   the final character of an address string. Accepted forms are
//   XX:XX:XX:XX:XX:XX, XXXX:XXXX:XXXX and XXXXXXXXXXXX, with ':' or '-'
//   separators that must all match.
//   Master stream emits one beat per string, on its final character:
//   tdata is the 48-bit address (first byte in the top bits), tuser holds
//   the valid flag and the format code. Invalid strings give zero address
//   and zero format.
//   The result beat is registered and presented in the cycle after the final
//   character is accepted. Throughput: one character per cycle; the only
//   limit is the single output register.
//   Stall: tready drops only while the output register holds a beat that
//   the receiver has not taken; no beat is lost or duplicated.
//   Reset: synchronous, active low; clears the string state and the output
//   valid, so the next beat starts a new string.
module mac_address_text_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [matp_pkg::CHAR_W-1:0]   i_s_axis_tdata,   // [7:0] char_code
    input  logic                          i_s_axis_tlast,   // last_char
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [matp_pkg::MAC_W-1:0]    o_m_axis_tdata,   // [47:0] mac_address
    output logic [2:0]                    o_m_axis_tuser    // [0] string_valid, [2:1] format_code
);
    import matp_pkg::*;

    t_char_class char_class;
    t_result     result;
    logic        s_beat;

    logic             r_m_valid;
    logic [MAC_W-1:0] r_m_data;
    logic [2:0]       r_m_user;

    // output register frees up in the same cycle it is drained
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_beat          = i_s_axis_tvalid && o_s_axis_tready;

    matp_char_decode u_decode (
        .i_char  (i_s_axis_tdata),
        .o_class (char_class)
    );

    matp_form_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (s_beat),
        .i_last   (i_s_axis_tlast),
        .i_char   (i_s_axis_tdata),
        .i_class  (char_class),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_beat && i_s_axis_tlast) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_beat && i_s_axis_tlast) begin
            r_m_data <= result.mac;
            r_m_user <= {result.fmt, result.valid};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

// ===== sv/matp_checker.sv =====
// Port-level checker for the MAC address text parser, bound to the top.
// Depends on matp_pkg and mac_address_text_parser_top.
module matp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        i_s_axis_tlast,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [matp_pkg::MAC_W-1:0]  o_m_axis_tdata,
    input logic [2:0]                  o_m_axis_tuser
);
    import matp_pkg::*;

    logic s_beat;
    assign s_beat = i_s_axis_tvalid && o_s_axis_tready;

    // rejected strings carry zero format and zero address
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |->
        (o_m_axis_tuser[2:1] == FMT_LONG && o_m_axis_tdata == '0))
        else $error("invalid result with nonzero payload");

    // a valid result names a defined format
    a_fmt_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
        (o_m_axis_tuser[2:1] == FMT_LONG || o_m_axis_tuser[2:1] == FMT_MIDDLE ||
         o_m_axis_tuser[2:1] == FMT_SHORT))
        else $error("undefined format code");

    // final character yields a result beat next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_beat && i_s_axis_tlast) |=> o_m_axis_tvalid)
        else $error("final character produced no result");

    // a new result only follows a final character
    a_result_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(s_beat && i_s_axis_tlast))
        else $error("result without final character");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind mac_address_text_parser_top matp_checker u_matp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== bench/mac_address_text_parser_top_tb.sv =====
// Testbench for mac_address_text_parser_top: streams MAC address text and checks parsed beats.
// Depends on matp_pkg and the parser RTL; a small in-bench model predicts every result beat.
`timescale 1ns / 1ps

module mac_address_text_parser_top_tb;
    import matp_pkg::*;

    typedef logic [CHAR_W-1:0] t_char_q[$];

    // Parser model plus the queue of result beats it still expects.
    class t_mac_parse_model;
        logic [POS_W-1:0]  pos;
        logic [MAC_W-1:0]  acc;
        logic              long_ok;
        logic              mid_ok;
        logic              short_ok;
        logic [CHAR_W-1:0] long_sep;
        logic [CHAR_W-1:0] mid_sep;
        t_result           pending_macs[$];
        int unsigned       mismatches;
        int unsigned       strings_seen;
        int unsigned       rejected;
        int unsigned       fmt_hits[3];

        function new();
            clear();
            mismatches   = 0;
            strings_seen = 0;
            rejected     = 0;
            fmt_hits     = '{0, 0, 0};
        endfunction

        function void clear();
            pos      = '0;
            acc      = '0;
            long_ok  = 1'b1;
            mid_ok   = 1'b1;
            short_ok = 1'b1;
            long_sep = '0;
            mid_sep  = '0;
        endfunction

        // One accepted character beat.
        function void take_char(logic [CHAR_W-1:0] c, logic last);
            logic             is_hex;
            logic [NIB_W-1:0] nib;
            logic [POS_W-1:0] p;
            t_result          r;
            is_hex = 1'b1;
            nib    = '0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                nib = NIB_W'(c - CH_ZERO);
            end else if (c >= CH_LO_A && c <= CH_LO_F) begin
                nib = NIB_W'(c - CH_LO_A) + NIB_TEN;
            end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                nib = NIB_W'(c - CH_UP_A) + NIB_TEN;
            end else begin
                is_hex = 1'b0;
            end
            p = pos;
            if (is_hex) acc = {acc[MAC_W-NIB_W-1:0], nib};

            if (p == POS_LONG_SEP0) begin
                if (c == CH_COLON || c == CH_DASH) long_sep = c;
                else long_ok = 1'b0;
            end else if (p == POS_LONG_SEP1 || p == POS_LONG_SEP2 ||
                         p == POS_LONG_SEP3 || p == POS_LONG_SEP4) begin
                if (c != long_sep) long_ok = 1'b0;
            end else if (p < LEN_LONG) begin
                if (!is_hex) long_ok = 1'b0;
            end

            if (p == POS_MID_SEP0) begin
                if (c == CH_COLON || c == CH_DASH) mid_sep = c;
                else mid_ok = 1'b0;
            end else if (p == POS_MID_SEP1) begin
                if (c != mid_sep) mid_ok = 1'b0;
            end else if (p < LEN_MIDDLE) begin
                if (!is_hex) mid_ok = 1'b0;
            end

            if (p < LEN_SHORT && !is_hex) short_ok = 1'b0;

            if (pos < POS_MAX) pos = pos + 1'b1;
            if (!last) return;

            r = '0;
            if (p < POS_MAX) begin
                if (pos == LEN_LONG && long_ok) begin
                    r.valid = 1'b1;
                    r.fmt   = FMT_LONG;
                end else if (pos == LEN_MIDDLE && mid_ok) begin
                    r.valid = 1'b1;
                    r.fmt   = FMT_MIDDLE;
                end else if (pos == LEN_SHORT && short_ok) begin
                    r.valid = 1'b1;
                    r.fmt   = FMT_SHORT;
                end
            end
            if (r.valid) r.mac = acc;
            pending_macs.push_back(r);
            strings_seen++;
            clear();
        endfunction

        // One accepted result beat against the oldest expectation.
        function void match_beat(logic [MAC_W-1:0] mac, logic [2:0] user);
            t_result want;
            if (pending_macs.size() == 0) begin
                $display("%0t: unexpected result beat, mac %h user %b", $time, mac, user);
                mismatches++;
                return;
            end
            want = pending_macs.pop_front();
            if (user[0] !== want.valid) begin
                $display("%0t: string_valid expected %b actual %b", $time, want.valid, user[0]);
                mismatches++;
            end
            if (user[2:1] !== want.fmt) begin
                $display("%0t: format_code expected %0d actual %0d", $time, want.fmt, user[2:1]);
                mismatches++;
            end
            if (mac !== want.mac) begin
                $display("%0t: mac_address expected %h actual %h", $time, want.mac, mac);
                mismatches++;
            end
            if (want.valid) fmt_hits[int'(want.fmt)]++;
            else rejected++;
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [CHAR_W-1:0] i_s_axis_tdata;
    logic              i_s_axis_tlast;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [MAC_W-1:0]  o_m_axis_tdata;
    logic [2:0]        o_m_axis_tuser;

    t_mac_parse_model board;
    bit               no_idle;     // both sides run flat out while set
    int unsigned      chars_sent;

    mac_address_text_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] char_code
        .i_s_axis_tlast  (i_s_axis_tlast),   // last_char
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [47:0] mac_address
        .o_m_axis_tuser  (o_m_axis_tuser)    // [0] string_valid, [2:1] format_code
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Both handshakes are sampled here at the rising edge. A result beat
    // is registered only after its final character is taken, so the order of
    // the two calls within one edge does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.match_beat(o_m_axis_tdata, o_m_axis_tuser);
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            board.take_char(i_s_axis_tdata, i_s_axis_tlast);
    end

    // Receiver back-pressure: drop ready about 23% of cycles, never while
    // the no-idle stretch runs.
    always @(negedge i_clk) begin
        i_m_axis_tready = no_idle || ($urandom_range(0, 99) >= 23);
    end

    // Random hex digit, either case for a-f.
    function automatic logic [CHAR_W-1:0] rand_hex();
        logic [NIB_W-1:0] n;
        n = NIB_W'($urandom_range(0, 15));
        if (n < NIB_TEN) return CHAR_W'(CH_ZERO + n);
        if ($urandom_range(0, 1)) return CHAR_W'(CH_UP_A + (n - NIB_TEN));
        return CHAR_W'(CH_LO_A + (n - NIB_TEN));
    endfunction

    // Well-formed string of the given format with random digits.
    function automatic t_char_q make_form(t_fmt form, logic [CHAR_W-1:0] sep);
        t_char_q q;
        int      len;
        bit      at_sep;
        len = (form == FMT_LONG) ? 17 : (form == FMT_MIDDLE) ? 14 : 12;
        for (int i = 0; i < len; i++) begin
            at_sep = (form == FMT_LONG)   ? (i % 3 == 2) :
                     (form == FMT_MIDDLE) ? (i == 4 || i == 9) : 1'b0;
            q.push_back(at_sep ? sep : rand_hex());
        end
        return q;
    endfunction

    // Present one character; returns once the beat is taken. Idle cycles
    // go in front of the beat, so gaps land at every string position.
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 23) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = c;
        i_s_axis_tlast  = last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_string(input t_char_q q);
        foreach (q[i]) send_char(q[i], i == q.size() - 1);
        chars_sent += q.size();
    endtask

    task automatic send_text(input string s);
        t_char_q q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        send_string(q);
    endtask

    // Mostly well-formed strings; the rest are single-character damage,
    // mixed separators, off-by-one lengths and pure noise.
    task automatic send_random_string();
        t_char_q           q;
        t_fmt              form;
        logic [CHAR_W-1:0] sep;
        logic [CHAR_W-1:0] other;
        int                r;
        int                k;
        case ($urandom_range(0, 2))
            0:       form = FMT_LONG;
            1:       form = FMT_MIDDLE;
            default: form = FMT_SHORT;
        endcase
        sep   = $urandom_range(0, 1) ? CH_COLON : CH_DASH;
        other = (sep == CH_COLON) ? CH_DASH : CH_COLON;
        q     = make_form(form, sep);
        r     = $urandom_range(0, 99);
        if (r < 60) begin
            // clean string
        end else if (r < 72) begin
            q[$urandom_range(0, q.size() - 1)] = CHAR_W'($urandom_range(0, 255));
        end else if (r < 80) begin
            // one separator swapped for the other legal one; short: a digit turned to sep
            if (form == FMT_LONG) q[2 + 3 * $urandom_range(0, 4)] = other;
            else if (form == FMT_MIDDLE) q[$urandom_range(0, 1) ? 9 : 4] = other;
            else q[$urandom_range(0, 11)] = sep;
        end else if (r < 88) begin
            if ($urandom_range(0, 1)) q.delete($urandom_range(0, q.size() - 1));
            else q.insert($urandom_range(0, q.size()), rand_hex());
        end else begin
            q.delete();
            k = $urandom_range(1, 40);
            repeat (k) begin
                case ($urandom_range(0, 2))
                    0:       q.push_back(CHAR_W'($urandom_range(0, 255)));
                    1:       q.push_back(rand_hex());
                    default: q.push_back($urandom_range(0, 1) ? CH_COLON : CH_DASH);
                endcase
            end
        end
        send_string(q);
    endtask

    initial begin
        t_char_q q;
        board           = new();
        no_idle         = 1'b0;
        chars_sent      = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: each form with both separators, all-zero and all-ones
        // addresses, mixed and illegal separators, wrong lengths.
        send_text("00:00:00:00:00:00");
        send_text("FF-ff-FF-ff-FF-ff");
        send_text("0123:4567:89aB");
        send_text("cdef-CDEF-0f0f");
        send_text("ffffffffffff");
        send_text("000000000000");
        send_text("12:34-56:78:9a:bc");
        send_text("0123:4567-89ab");
        send_text("12.34.56.78.9a.bc");
        send_text("1234_5678_9abc");
        send_text("0123456789AG");
        send_text("12345678901");
        send_text("12:34:56:78:9a:bc:");
        send_text("1");
        // hex range boundaries, and control / high bytes in a short string
        send_text("/:@G`g");
        q = make_form(FMT_SHORT, CH_COLON);
        q[0]  = 8'h00;
        q[11] = 8'hFF;
        send_string(q);
        // string long enough to saturate the position counter
        q.delete();
        repeat (40) q.push_back(rand_hex());
        send_string(q);

        // Random part, with one long stretch where neither side idles.
        while (chars_sent < 1250) begin
            no_idle = (chars_sent >= 550 && chars_sent < 800);
            send_random_string();
        end
        no_idle         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast  = 1'b0;

        while (board.pending_macs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d characters in %0d strings; %0d rejected strings.",
                 chars_sent, board.strings_seen, board.rejected);
        $display("Valid addresses by form: long %0d, middle %0d, short %0d.",
                 board.fmt_hits[0], board.fmt_hits[1], board.fmt_hits[2]);
        if (board.mismatches == 0 && board.pending_macs.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
